// ===== hdl/skl_pkg.sv =====
// package for the sorted key list: command and result item types,
// status and function codes, default capacity
// no dependencies
package skl_pkg;

	localparam int SKL_CAPACITY = 16;
	localparam int KEY_W        = 32;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic                    func;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [4:0]              count;
		logic                    empty_res;
		logic signed [KEY_W-1:0] smallest_key;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                    cmp_en;
		logic signed [KEY_W-1:0] cmp_key;
		logic                    ins;
		logic                    rem;
		logic signed [KEY_W-1:0] new_key;
	} cell_ctl_t;

	// what a cell shows to its neighbors
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic                    valid;
		logic                    less;
		logic                    eq;
	} cell_link_t;

endpackage

// ===== hdl/sorted_key_list_core.sv =====
// sorted key list top level: command control, status and count, and the
// chain of key cells that keeps the keys in ascending order
// depends on skl_pkg and skl_cell
//
// An item is taken when start is high and busy is low. In the cycle it is
// taken every cell compares its key with the item's key, and in the next
// cycle (busy high) the cells from the insert position on shift one place
// right for an insert, or those from the first equal key one place left for
// a remove. The result is shown on rsp for one cycle with done high, the cycle
// after that shift; it cannot be held off, and a new item may be taken in that
// same cycle. An insert into a full list, a remove from an empty one and a
// remove of an absent key leave the keys unchanged and report it in status.
module sorted_key_list_core import skl_pkg::*; #(
	parameter int CAPACITY = SKL_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                    busy_q;
	logic                    done_q;
	logic                    func_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	status_t                 status_q;
	logic                    full;
	logic                    found;
	logic                    accept;
	logic [CAPACITY-1:0]     eq_vec;
	logic [CNT_W+4:0]        count_ext;
	cell_ctl_t               ctl;
	cell_link_t              links [CAPACITY];
	cell_link_t              head_prev;
	cell_link_t              tail_next;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign full   = count_q == CNT_W'(CAPACITY);
	assign found  = |eq_vec;

	assign ctl.cmp_en  = accept;
	assign ctl.cmp_key = cmd.key;
	assign ctl.ins     = busy_q && (func_q == FUNC_INSERT) && !full;
	assign ctl.rem     = busy_q && (func_q == FUNC_REMOVE) && found;
	assign ctl.new_key = key_q;

	assign head_prev = '{key: '0, valid: 1'b1, less: 1'b1, eq: 1'b0};
	assign tail_next = '{key: '0, valid: 1'b0, less: 1'b0, eq: 1'b0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   ((i == 0) ? head_prev : links[(i == 0) ? 0 : i - 1]),
			.next   ((i == CAPACITY - 1) ? tail_next
			                             : links[(i == CAPACITY - 1) ? i : i + 1]),
			.link   (links[i])
		);
		assign eq_vec[i] = links[i].eq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			status_q <= ST_DONE;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				case (func_q)
					FUNC_INSERT: begin
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_DONE;
							count_q  <= count_q + CNT_W'(1);
						end
					end
					FUNC_REMOVE: begin
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
						end else if (!found) begin
							status_q <= ST_NOT_FOUND;
						end else begin
							status_q <= ST_DONE;
							count_q  <= count_q - CNT_W'(1);
						end
					end
					default: status_q <= ST_DONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			key_q  <= cmd.key;
		end
	end

	assign count_ext        = {5'b0, count_q};
	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.count        = count_ext[4:0];
	assign rsp.empty_res    = count_q == '0;
	assign rsp.smallest_key = (count_q == '0) ? '0 : links[0].key;

	// count stays within the list size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("key count above capacity");

	// a result follows exactly one update cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("result without update cycle");

	// the first cell is held exactly when the count is nonzero
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		links[0].valid == (count_q != '0))
		else $error("head cell validity disagrees with count");

	// a failed operation leaves the count alone
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q != ST_DONE) |-> $stable(count_q))
		else $error("count changed on failed operation");

endmodule

// ===== hdl/skl_cell.sv =====
// one slot of the sorted key chain: holds a key, compares it with the
// incoming item and shifts toward either neighbor on update
// depends on skl_pkg
module skl_cell import skl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_link_t prev,
	input  cell_link_t next,
	output cell_link_t link
);

	logic signed [KEY_W-1:0] key_q;
	logic                    valid_q;
	logic                    less_q;
	logic                    eq_q;
	logic                    prev_at_or_after;
	logic                    own_at_or_after;
	logic                    own_match_region;

	// insert position: first slot that is empty or holds a key not smaller
	assign prev_at_or_after = !prev.valid || !prev.less;
	assign own_at_or_after  = !valid_q || !less_q;
	// remove region: held keys from the first equal one on
	assign own_match_region = valid_q && !less_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			less_q  <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				less_q <= key_q < ctl.cmp_key;
				eq_q   <= valid_q && (key_q == ctl.cmp_key);
			end
			if (ctl.ins) begin
				valid_q <= valid_q || prev.valid;
			end else if (ctl.rem && own_match_region) begin
				valid_q <= next.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_at_or_after) begin
				key_q <= prev.key;
			end else if (own_at_or_after) begin
				key_q <= ctl.new_key;
			end
		end else if (ctl.rem && own_match_region) begin
			key_q <= next.key;
		end
	end

	assign link.key   = key_q;
	assign link.valid = valid_q;
	assign link.less  = less_q;
	assign link.eq    = eq_q;

endmodule
